>>> rtl/sgd_pkg.sv
// Package of types and constants shared by the swing gesture detector.
`timescale 1ns / 1ps

package sgd_pkg;

  // Widths of the configuration registers and payload fields.
  localparam int unsigned THR_W   = 12;
  localparam int unsigned KEY_W   = 4;
  localparam int unsigned ACCEL_W = 16;
  localparam int unsigned INDEX_W = 2;

  // Register indexes on the configuration port.
  localparam logic [INDEX_W-1:0] REG_BASE_THRESHOLD  = 2'd0;
  localparam logic [INDEX_W-1:0] REG_AFTER_SWING     = 2'd1;
  localparam logic [INDEX_W-1:0] REG_DECAY_STEP      = 2'd2;
  localparam logic [INDEX_W-1:0] REG_RELEASE_MARGIN  = 2'd3;

  // Reset values of the configuration registers.
  localparam logic [THR_W-1:0] RESET_BASE_THRESHOLD = 12'd200;
  localparam logic [THR_W-1:0] RESET_AFTER_SWING    = 12'd500;
  localparam logic [THR_W-1:0] RESET_DECAY_STEP     = 12'd10;
  localparam logic [THR_W-1:0] RESET_RELEASE_MARGIN = 12'd50;

  // Extra headroom the z axis must clear for an upward swing.
  localparam logic [THR_W-1:0] Z_EXTRA = 12'd100;

  // Key codes: none, then left/right/up for sensor 0 and sensor 1.
  localparam logic [KEY_W-1:0] KEY_NONE     = 4'h0;
  localparam logic [KEY_W-1:0] KEY_LEFT_S0  = 4'h8;
  localparam logic [KEY_W-1:0] KEY_RIGHT_S0 = 4'h9;
  localparam logic [KEY_W-1:0] KEY_UP_S0    = 4'hA;
  localparam logic [KEY_W-1:0] KEY_LEFT_S1  = 4'hB;
  localparam logic [KEY_W-1:0] KEY_RIGHT_S1 = 4'hC;
  localparam logic [KEY_W-1:0] KEY_UP_S1    = 4'hD;

  // Current configuration, as handed from the register file to the datapath.
  typedef struct packed {
    logic [THR_W-1:0] base_threshold;
    logic [THR_W-1:0] after_swing_threshold;
    logic [THR_W-1:0] decay_step;
    logic [THR_W-1:0] release_margin;
  } sgd_cfg_t;

endpackage

>>> rtl/sgd_cfg_regs.sv
// Configuration register file of the swing gesture detector.
`timescale 1ns / 1ps

module sgd_cfg_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_enable,
  input  logic [sgd_pkg::INDEX_W-1:0] cfg_index,
  input  logic [sgd_pkg::THR_W-1:0]   cfg_write_data,
  output sgd_pkg::sgd_cfg_t          cfg
);

  // Registers load their defaults on reset and take writes by index.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base_threshold        <= sgd_pkg::RESET_BASE_THRESHOLD;
      cfg.after_swing_threshold <= sgd_pkg::RESET_AFTER_SWING;
      cfg.decay_step            <= sgd_pkg::RESET_DECAY_STEP;
      cfg.release_margin        <= sgd_pkg::RESET_RELEASE_MARGIN;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        sgd_pkg::REG_BASE_THRESHOLD: cfg.base_threshold        <= cfg_write_data;
        sgd_pkg::REG_AFTER_SWING:    cfg.after_swing_threshold <= cfg_write_data;
        sgd_pkg::REG_DECAY_STEP:     cfg.decay_step            <= cfg_write_data;
        sgd_pkg::REG_RELEASE_MARGIN: cfg.release_margin        <= cfg_write_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/sgd_step.sv
// Combinational release, decay and swing detection for one sample.
`timescale 1ns / 1ps

module sgd_step (
  input  sgd_pkg::sgd_cfg_t                 cfg,
  input  logic                              sensor,
  input  logic signed [sgd_pkg::ACCEL_W-1:0] accel_x,
  input  logic signed [sgd_pkg::ACCEL_W-1:0] accel_y,
  input  logic signed [sgd_pkg::ACCEL_W-1:0] accel_z,
  input  logic [sgd_pkg::THR_W-1:0]          thr,
  input  logic [sgd_pkg::KEY_W-1:0]          key,
  output logic [sgd_pkg::THR_W-1:0]          thr_next,
  output logic [sgd_pkg::KEY_W-1:0]          key_next,
  output logic                              changed
);

  localparam int unsigned CMP_W = sgd_pkg::ACCEL_W + 1;

  logic signed [sgd_pkg::THR_W+1:0] release_level;
  logic                             release_key;
  logic [sgd_pkg::THR_W-1:0]        thr_decayed;
  logic signed [CMP_W-1:0]          t_pos;
  logic signed [CMP_W-1:0]          t_neg;
  logic signed [CMP_W-1:0]          t_z;
  logic signed [CMP_W-1:0]          x_ext;
  logic signed [CMP_W-1:0]          y_ext;
  logic signed [CMP_W-1:0]          z_ext;
  logic                             hit_left;
  logic                             hit_right;
  logic                             hit_up;
  logic [sgd_pkg::KEY_W-1:0]        key_left;
  logic [sgd_pkg::KEY_W-1:0]        key_right;
  logic [sgd_pkg::KEY_W-1:0]        key_up;
  logic [sgd_pkg::KEY_W-1:0]        key_released;

  // Release: the key is dropped while the threshold sits near the after-swing level.
  // The difference is signed, so a margin above after-swing always releases.
  assign release_level = $signed({2'b00, cfg.after_swing_threshold})
                       - $signed({2'b00, cfg.release_margin});
  assign release_key   = $signed({2'b00, thr}) > release_level;
  assign key_released  = release_key ? sgd_pkg::KEY_NONE : key;

  // Decay towards base, saturating at zero.
  always_comb begin
    thr_decayed = thr;
    if (thr > cfg.base_threshold) begin
      thr_decayed = (thr > cfg.decay_step) ? thr - cfg.decay_step : '0;
    end
  end

  // Sign-extend the axes and form the comparison levels.
  assign x_ext = CMP_W'(accel_x);
  assign y_ext = CMP_W'(accel_y);
  assign z_ext = CMP_W'(accel_z);
  assign t_pos = $signed(CMP_W'(thr_decayed));
  assign t_neg = -t_pos;
  assign t_z   = $signed(CMP_W'(thr_decayed) + CMP_W'(sgd_pkg::Z_EXTRA));

  assign hit_left  = x_ext > t_pos;
  assign hit_right = x_ext < t_neg;
  assign hit_up    = (z_ext > t_z) || (y_ext > t_pos);

  // Key codes of the selected sensor.
  assign key_left  = sensor ? sgd_pkg::KEY_LEFT_S1  : sgd_pkg::KEY_LEFT_S0;
  assign key_right = sensor ? sgd_pkg::KEY_RIGHT_S1 : sgd_pkg::KEY_RIGHT_S0;
  assign key_up    = sensor ? sgd_pkg::KEY_UP_S1    : sgd_pkg::KEY_UP_S0;

  // Detection in priority order; any swing reloads the after-swing threshold.
  always_comb begin
    key_next = key_released;
    thr_next = thr_decayed;
    if (hit_left) begin
      key_next = key_left;
      thr_next = cfg.after_swing_threshold;
    end else if (hit_right) begin
      key_next = key_right;
      thr_next = cfg.after_swing_threshold;
    end else if (hit_up) begin
      key_next = key_up;
      thr_next = cfg.after_swing_threshold;
    end
  end

  assign changed = key_next != key;

endmodule

>>> rtl/swing_gesture_detector_top.sv
// Top level of the swing gesture detector.
`timescale 1ns / 1ps

// Swing gesture detector for two accelerometers. One sample request is taken
// every clock cycle unless sample_stall is raised; each gives exactly one result
// request, passing through the sample register and then the result register.
// The per-sensor threshold and held key are updated as the sample moves into
// the result register, so a sample that follows directly reads the state left
// by the one before it. Configuration writes take effect from the next sample
// and do not reload stored thresholds.
module swing_gesture_detector_top (
  input  logic                               clk,
  input  logic                               rst,
  // Sample channel
  input  logic                               sample_valid,
  output logic                               sample_stall,
  input  logic                               sensor_select,
  input  logic signed [sgd_pkg::ACCEL_W-1:0] accel_x,
  input  logic signed [sgd_pkg::ACCEL_W-1:0] accel_y,
  input  logic signed [sgd_pkg::ACCEL_W-1:0] accel_z,
  // Result channel
  output logic                               result_valid,
  input  logic                               result_stall,
  output logic                               sensor_id,
  output logic [sgd_pkg::KEY_W-1:0]          key_code,
  output logic                               key_changed,
  // Configuration port
  input  logic                               cfg_write_enable,
  input  logic [sgd_pkg::INDEX_W-1:0]        cfg_index,
  input  logic [sgd_pkg::THR_W-1:0]          cfg_write_data
);

  sgd_pkg::sgd_cfg_t                 cfg;

  logic                              s_valid;
  logic                              s_sensor;
  logic signed [sgd_pkg::ACCEL_W-1:0] s_x;
  logic signed [sgd_pkg::ACCEL_W-1:0] s_y;
  logic signed [sgd_pkg::ACCEL_W-1:0] s_z;
  logic                              out_blocked;
  logic                              s_advance;

  logic [sgd_pkg::THR_W-1:0]         thr_state [2];
  logic [sgd_pkg::KEY_W-1:0]         key_state [2];
  logic [sgd_pkg::THR_W-1:0]         thr_next;
  logic [sgd_pkg::KEY_W-1:0]         key_next;
  logic                              changed_next;

  sgd_cfg_regs u_cfg (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_write_data   (cfg_write_data),
    .cfg              (cfg)
  );

  // Handshake: the result register frees up whenever it is empty or being taken.
  assign out_blocked  = result_valid & result_stall;
  assign s_advance    = s_valid & ~out_blocked;
  assign sample_stall = s_valid & out_blocked;

  // Sample register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (!sample_stall) begin
      s_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall) begin
      s_sensor <= sensor_select;
      s_x      <= accel_x;
      s_y      <= accel_y;
      s_z      <= accel_z;
    end
  end

  // Per-sample datapath on the selected sensor's state.
  sgd_step u_step (
    .cfg      (cfg),
    .sensor   (s_sensor),
    .accel_x  (s_x),
    .accel_y  (s_y),
    .accel_z  (s_z),
    .thr      (thr_state[s_sensor]),
    .key      (key_state[s_sensor]),
    .thr_next (thr_next),
    .key_next (key_next),
    .changed  (changed_next)
  );

  // Per-sensor threshold and held key, written as the sample leaves.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_state[0] <= sgd_pkg::RESET_BASE_THRESHOLD;
      thr_state[1] <= sgd_pkg::RESET_BASE_THRESHOLD;
      key_state[0] <= sgd_pkg::KEY_NONE;
      key_state[1] <= sgd_pkg::KEY_NONE;
    end else if (s_advance) begin
      thr_state[s_sensor] <= thr_next;
      key_state[s_sensor] <= key_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (!out_blocked) begin
      result_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_advance) begin
      sensor_id   <= s_sensor;
      key_code    <= key_next;
      key_changed <= changed_next;
    end
  end

endmodule

>>> rtl/sgd_checker.sv
// Port-level checker for the swing gesture detector, bound to the top level.
`timescale 1ns / 1ps

module sgd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic                      sensor_id,
  input logic [sgd_pkg::KEY_W-1:0] key_code,
  input logic                      key_changed
);

  logic [sgd_pkg::KEY_W-1:0] last_key [2];
  logic                      result_taken;

  assign result_taken = result_valid & ~result_stall;

  // Last key delivered for each sensor, as seen on the result channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_key[0] <= sgd_pkg::KEY_NONE;
      last_key[1] <= sgd_pkg::KEY_NONE;
    end else if (result_taken) begin
      last_key[sensor_id] <= key_code;
    end
  end

  // A stalled result holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(sensor_id) && $stable(key_code) && $stable(key_changed))
    else $error("stalled result changed");

  // The changed flag agrees with the previous key delivered for that sensor.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |-> key_changed == (key_code != last_key[sensor_id]))
    else $error("key_changed disagrees with key history");

  // Each sensor only reports its own key codes.
  assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (key_code == sgd_pkg::KEY_NONE) ||
      (!sensor_id && (key_code == sgd_pkg::KEY_LEFT_S0 ||
                      key_code == sgd_pkg::KEY_RIGHT_S0 ||
                      key_code == sgd_pkg::KEY_UP_S0)) ||
      (sensor_id && (key_code == sgd_pkg::KEY_LEFT_S1 ||
                     key_code == sgd_pkg::KEY_RIGHT_S1 ||
                     key_code == sgd_pkg::KEY_UP_S1)))
    else $error("key code does not belong to the sensor");

  // No result is offered straight after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind swing_gesture_detector_top sgd_checker u_sgd_checker (.*);
